@@ rtl/lcdlt_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdlt_pkg
// shared constants and types for the lcd line timing block
// ----------------------------------------------------------------------------
package lcdlt_pkg;

    // frame geometry
    localparam int LINE_DOTS         = 456;
    localparam int FRAME_LINES       = 154;
    localparam int LAST_VISIBLE_LINE = 143;

    localparam int DOT_W  = 9;
    localparam int LINE_W = 8;

    localparam logic [DOT_W:0]    LINE_DOTS_C   = (DOT_W+1)'(LINE_DOTS);
    localparam logic [LINE_W-1:0] FRAME_LINES_C = LINE_W'(FRAME_LINES);
    localparam logic [LINE_W-1:0] LAST_VIS_C    = LINE_W'(LAST_VISIBLE_LINE);
    localparam logic [LINE_W-1:0] VBLANK_LINE_C = LINE_W'(LAST_VISIBLE_LINE + 1);

    // dot positions within a visible line
    localparam logic [DOT_W-1:0] XFER_DOT_NORMAL    = DOT_W'(84);
    localparam logic [DOT_W-1:0] RSTART_DOT_NORMAL  = DOT_W'(89);
    localparam logic [DOT_W-1:0] XFER_DOT_STARTUP   = DOT_W'(87);
    localparam logic [DOT_W-1:0] RSTART_DOT_STARTUP = DOT_W'(92);
    localparam logic [DOT_W-1:0] OAM_DOT            = DOT_W'(4);
    localparam logic [DOT_W-1:0] STARTUP_DOT        = DOT_W'(7);

    // reported stat mode codes
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    // internal mode, one-hot
    typedef enum logic [3:0] {
        ST_HBLANK = 4'b0001,
        ST_VBLANK = 4'b0010,
        ST_OAM    = 4'b0100,
        ST_XFER   = 4'b1000
    } inner_mode_t;

    typedef struct packed {
        logic [DOT_W-1:0]  dot;
        logic [LINE_W-1:0] line;
        inner_mode_t       inner;
        logic [1:0]        shown;
        logic              on;
        logic              startup;
        logic              skip;
        logic              win;
    } lcdlt_state_t;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [DOT_W-1:0]  dot;
        logic [1:0]        stat_mode;
        logic              lyc_match;
        logic              vblank_irq;
        logic              oam_irq;
        logic              hblank_start;
        logic              render_start;
        logic              window_line_hit;
        logic              frame_commit;
        logic              screen_clear;
    } lcdlt_result_t;

endpackage

@@ rtl/lcdlt_step.sv @@
// ----------------------------------------------------------------------------
// lcdlt_step
// one dot tick of line timing: next state and result from current state
// ----------------------------------------------------------------------------
module lcdlt_step
    import lcdlt_pkg::*;
(
    input  lcdlt_state_t      state,
    input  logic              lcd_enable,
    input  logic [7:0]        lyc,
    input  logic [7:0]        wy,
    input  logic              transfer_done,
    output lcdlt_state_t      state_next,
    output lcdlt_result_t     result
);

    always_comb
    begin
        lcdlt_state_t      s;
        logic [DOT_W-1:0]  dot_inc;
        logic [LINE_W-1:0] line_inc;
        logic [DOT_W-1:0]  xd;
        logic [DOT_W-1:0]  rs;
        logic              vbl;
        logic              oam;
        logic              hbl;
        logic              rst;
        logic              commit;
        logic              clr;

        s        = state;
        vbl      = 1'b0;
        oam      = 1'b0;
        hbl      = 1'b0;
        rst      = 1'b0;
        commit   = 1'b0;
        clr      = 1'b0;
        dot_inc  = '0;
        line_inc = '0;
        xd       = '0;
        rs       = '0;

        if (!lcd_enable)
        begin
            if (s.on)
            begin
                s.on      = 1'b0;
                s.startup = 1'b0;
                s.dot     = '0;
                s.line    = '0;
                s.inner   = ST_HBLANK;
                s.shown   = MODE_HBLANK;
                s.win     = 1'b0;
                clr       = 1'b1;
            end
        end
        else
        begin
            // turn on: startup line begins at a later dot
            if (!s.on)
            begin
                s.on      = 1'b1;
                s.startup = 1'b1;
                s.skip    = 1'b1;
                s.dot     = STARTUP_DOT;
                s.line    = '0;
                s.inner   = ST_HBLANK;
                s.shown   = MODE_HBLANK;
                clr       = 1'b1;
            end

            // end of pixel transfer
            rs = s.startup ? RSTART_DOT_STARTUP : RSTART_DOT_NORMAL;
            if (s.inner == ST_XFER && s.dot >= rs && transfer_done)
            begin
                s.inner = ST_HBLANK;
                s.shown = MODE_HBLANK;
                hbl     = (s.line <= LAST_VIS_C);
            end

            dot_inc = s.dot + DOT_W'(1);
            if ({1'b0, dot_inc} >= LINE_DOTS_C || dot_inc == '0)
            begin
                // line boundary
                s.dot    = '0;
                line_inc = s.line + LINE_W'(1);
                if (line_inc >= FRAME_LINES_C)
                    line_inc = line_inc - FRAME_LINES_C;
                s.line = line_inc;
                if (s.line > LAST_VIS_C)
                begin
                    s.inner = ST_VBLANK;
                    s.shown = MODE_VBLANK;
                    s.win   = 1'b0;
                    if (s.line == VBLANK_LINE_C)
                    begin
                        vbl = 1'b1;
                        if (s.skip)
                            s.skip = 1'b0;
                        else
                            commit = 1'b1;
                    end
                end
                else
                begin
                    s.inner = ST_OAM;
                    oam     = (s.line != '0);
                end
            end
            else
            begin
                s.dot = dot_inc;
                if (s.line <= LAST_VIS_C)
                begin
                    xd = s.startup ? XFER_DOT_STARTUP : XFER_DOT_NORMAL;
                    rs = s.startup ? RSTART_DOT_STARTUP : RSTART_DOT_NORMAL;
                    if (!s.startup && s.dot == OAM_DOT)
                    begin
                        s.shown = MODE_OAM;
                        if (s.line == '0)
                            oam = 1'b1;
                    end
                    if (s.dot == xd)
                    begin
                        s.inner = ST_XFER;
                        s.shown = MODE_XFER;
                    end
                    if (s.dot == rs)
                    begin
                        rst = 1'b1;
                        if (!s.win && s.line == wy)
                            s.win = 1'b1;
                        s.startup = 1'b0;
                    end
                end
            end
        end

        state_next = s;

        result.line            = s.line;
        result.dot             = s.dot;
        result.stat_mode       = s.shown;
        result.lyc_match       = (s.line == lyc);
        result.vblank_irq      = vbl;
        result.oam_irq         = oam;
        result.hblank_start    = hbl;
        result.render_start    = rst;
        result.window_line_hit = s.win;
        result.frame_commit    = commit;
        result.screen_clear    = clr;
    end

endmodule

@@ rtl/lcd_line_timing.sv @@
// ----------------------------------------------------------------------------
// lcd_line_timing
// dot-clocked scanline and mode timing for an lcd controller
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_ready): one request per dot tick carrying
//   lcd_enable, lyc, wy and transfer_done from the renderer
//   output channel (out_valid / out_ready): one result per request with ly,
//   dot, stat mode, lyc match, window line flag and the event pulses
//   result: registered, valid in the cycle after its request is accepted
//   throughput: one request per cycle; the timing state update is a single
//   pass of combinational logic between the timing registers and the result
//   register, so only a stall limits the rate below one dot per clock
//   the result register acts as a pipe stage: a new request is taken while
//   the previous result is taken in the same cycle
//   stall: while a result waits on out_ready, in_ready drops and the timing
//   state holds; no dot is lost or repeated
//   reset: display off, line 0, dot 0, hblank, all flags clear, no result
//   pending; the first enabled tick starts the startup line at dot 7
// ----------------------------------------------------------------------------
module lcd_line_timing
    import lcdlt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic              lcd_enable,
    input  logic [7:0]        lyc,
    input  logic [7:0]        wy,
    input  logic              transfer_done,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [LINE_W-1:0] line,
    output logic [DOT_W-1:0]  dot,
    output logic [1:0]        stat_mode,
    output logic              lyc_match,
    output logic              vblank_irq,
    output logic              oam_irq,
    output logic              hblank_start,
    output logic              render_start,
    output logic              window_line_hit,
    output logic              frame_commit,
    output logic              screen_clear
);

    // timing state (counters, modes, flags)
    lcdlt_state_t  state_reg;
    lcdlt_state_t  state_next;

    // result stage
    lcdlt_result_t result_reg;
    lcdlt_result_t result_next;
    logic          out_valid_reg;

    logic          in_accept;

    // take a request whenever the result slot is empty or being drained
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    lcdlt_step u_step
    (
        .state         (state_reg),
        .lcd_enable    (lcd_enable),
        .lyc           (lyc),
        .wy            (wy),
        .transfer_done (transfer_done),
        .state_next    (state_next),
        .result        (result_next)
    );

    // state only advances on an accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.dot     <= '0;
            state_reg.line    <= '0;
            state_reg.inner   <= ST_HBLANK;
            state_reg.shown   <= MODE_HBLANK;
            state_reg.on      <= 1'b0;
            state_reg.startup <= 1'b0;
            state_reg.skip    <= 1'b0;
            state_reg.win     <= 1'b0;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
            result_reg <= result_next;
    end

    assign out_valid       = out_valid_reg;
    assign line            = result_reg.line;
    assign dot             = result_reg.dot;
    assign stat_mode       = result_reg.stat_mode;
    assign lyc_match       = result_reg.lyc_match;
    assign vblank_irq      = result_reg.vblank_irq;
    assign oam_irq         = result_reg.oam_irq;
    assign hblank_start    = result_reg.hblank_start;
    assign render_start    = result_reg.render_start;
    assign window_line_hit = result_reg.window_line_hit;
    assign frame_commit    = result_reg.frame_commit;
    assign screen_clear    = result_reg.screen_clear;

    // counters stay inside the frame geometry
    a_dot_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, state_reg.dot} < LINE_DOTS_C)
        else $error("dot counter beyond line length");

    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.line < FRAME_LINES_C)
        else $error("line counter beyond frame length");

    // display off holds timing at the origin
    a_off_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.on |-> (state_reg.dot == '0 && state_reg.line == '0
                           && state_reg.inner == ST_HBLANK))
        else $error("timing not held while display off");

    // a frame commit only happens together with vblank start
    a_commit_vbl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_commit) |-> (vblank_irq && line == VBLANK_LINE_C))
        else $error("frame commit outside vblank start");

    // an accepted request always leaves a result pending
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid)
        else $error("accepted request produced no result");

endmodule

@@ tb/lcd_timing_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_timing_checker
// watches both channels of the line timing block, predicts each result
// from the accepted dot tick requests and compares them field by field
// ----------------------------------------------------------------------------
module lcd_timing_checker
    import lcdlt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              lcd_enable,
    input  logic [7:0]        lyc,
    input  logic [7:0]        wy,
    input  logic              transfer_done,

    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [LINE_W-1:0] line,
    input  logic [DOT_W-1:0]  dot,
    input  logic [1:0]        stat_mode,
    input  logic              lyc_match,
    input  logic              vblank_irq,
    input  logic              oam_irq,
    input  logic              hblank_start,
    input  logic              render_start,
    input  logic              window_line_hit,
    input  logic              frame_commit,
    input  logic              screen_clear,

    output int                error_count,
    output int                ticks_outstanding,
    output int                ticks_checked,
    output int                vblank_count,
    output int                commit_count
);

    // predicted timing state
    logic [DOT_W-1:0]  dot_q;
    logic [LINE_W-1:0] line_q;
    inner_mode_t       inner_q;
    logic [1:0]        shown_q;
    logic              on_q;
    logic              startup_q;
    logic              skip_q;
    logic              win_q;

    lcdlt_result_t     ticks_due[$];

    // advance the timing state by one dot and return what the block shows
    function automatic lcdlt_result_t step_dot_clock(input logic en,
                                                     input logic [7:0] cmp,
                                                     input logic [7:0] wline,
                                                     input logic done);
        lcdlt_result_t    r;
        logic [DOT_W-1:0] xfer_at;
        logic [DOT_W-1:0] rstart_at;
        int               nxt;
        r = '0;
        if (!en)
        begin
            if (on_q)
            begin
                on_q      = 1'b0;
                startup_q = 1'b0;
                dot_q     = '0;
                line_q    = '0;
                inner_q   = ST_HBLANK;
                shown_q   = MODE_HBLANK;
                win_q     = 1'b0;
                r.screen_clear = 1'b1;
            end
        end
        else
        begin
            if (!on_q)
            begin
                on_q      = 1'b1;
                startup_q = 1'b1;
                skip_q    = 1'b1;
                dot_q     = STARTUP_DOT;
                line_q    = '0;
                inner_q   = ST_HBLANK;
                shown_q   = MODE_HBLANK;
                r.screen_clear = 1'b1;
            end
            xfer_at   = startup_q ? XFER_DOT_STARTUP : XFER_DOT_NORMAL;
            rstart_at = startup_q ? RSTART_DOT_STARTUP : RSTART_DOT_NORMAL;

            // renderer done only counts in transfer from the render start dot on
            if (inner_q == ST_XFER && dot_q >= rstart_at && done)
            begin
                inner_q = ST_HBLANK;
                shown_q = MODE_HBLANK;
                if (line_q <= LAST_VIS_C)
                    r.hblank_start = 1'b1;
            end

            nxt = (int'(dot_q) + 1) % 512;
            if (nxt >= LINE_DOTS || nxt == 0)
            begin
                dot_q  = '0;
                line_q = LINE_W'(((int'(line_q) + 1) % 256) % FRAME_LINES);
                if (line_q > LAST_VIS_C)
                begin
                    inner_q = ST_VBLANK;
                    shown_q = MODE_VBLANK;
                    win_q   = 1'b0;
                    if (line_q == VBLANK_LINE_C)
                    begin
                        r.vblank_irq = 1'b1;
                        if (skip_q)
                            skip_q = 1'b0;
                        else
                            r.frame_commit = 1'b1;
                    end
                end
                else
                begin
                    inner_q = ST_OAM;
                    if (line_q != '0)
                        r.oam_irq = 1'b1;
                end
            end
            else
            begin
                dot_q = DOT_W'(nxt);
                if (line_q <= LAST_VIS_C)
                begin
                    if (!startup_q && dot_q == OAM_DOT)
                    begin
                        shown_q = MODE_OAM;
                        if (line_q == '0)
                            r.oam_irq = 1'b1;
                    end
                    if (dot_q == xfer_at)
                    begin
                        inner_q = ST_XFER;
                        shown_q = MODE_XFER;
                    end
                    if (dot_q == rstart_at)
                    begin
                        r.render_start = 1'b1;
                        if (!win_q && line_q == wline)
                            win_q = 1'b1;
                        startup_q = 1'b0;
                    end
                end
            end
        end
        r.line            = line_q;
        r.dot             = dot_q;
        r.stat_mode       = shown_q;
        r.lyc_match       = (line_q == cmp);
        r.window_line_hit = win_q;
        return r;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lcdlt_result_t want;
        if (!rst_n)
        begin
            dot_q     = '0;
            line_q    = '0;
            inner_q   = ST_HBLANK;
            shown_q   = MODE_HBLANK;
            on_q      = 1'b0;
            startup_q = 1'b0;
            skip_q    = 1'b0;
            win_q     = 1'b0;
            ticks_due.delete();
            error_count       = 0;
            ticks_outstanding = 0;
            ticks_checked     = 0;
            vblank_count      = 0;
            commit_count      = 0;
        end
        else
        begin
            // results first: a request taken at this edge cannot be answered yet
            if (out_valid && out_ready)
            begin
                if (ticks_due.size() == 0)
                begin
                    $error("result with no request waiting: line %0d dot %0d", line, dot);
                    error_count++;
                end
                else
                begin
                    want = ticks_due.pop_front();
                    compare_field("line", want.line, line);
                    compare_field("dot", want.dot, dot);
                    compare_field("stat_mode", want.stat_mode, stat_mode);
                    compare_field("lyc_match", want.lyc_match, lyc_match);
                    compare_field("vblank_irq", want.vblank_irq, vblank_irq);
                    compare_field("oam_irq", want.oam_irq, oam_irq);
                    compare_field("hblank_start", want.hblank_start, hblank_start);
                    compare_field("render_start", want.render_start, render_start);
                    compare_field("window_line_hit", want.window_line_hit,
                                  window_line_hit);
                    compare_field("frame_commit", want.frame_commit, frame_commit);
                    compare_field("screen_clear", want.screen_clear, screen_clear);
                    ticks_checked++;
                    if (want.vblank_irq)
                        vblank_count++;
                    if (want.frame_commit)
                        commit_count++;
                end
            end
            if (in_valid && in_ready)
                ticks_due.push_back(step_dot_clock(lcd_enable, lyc, wy, transfer_done));
            ticks_outstanding = ticks_due.size();
        end
    end

endmodule

@@ tb/lcd_line_timing_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_line_timing_tb
// drives dot tick requests into the line timing block: a short directed
// pass over display off, turn on and stray transfer done, random noise with
// display toggling, then a stretch of lines with the display held on and
// random renderer timing; the checker beside the block predicts and compares
// every result
// ----------------------------------------------------------------------------
module lcd_line_timing_tb;
    import lcdlt_pkg::*;

    localparam int NOISE_TICKS    = 500;
    localparam int FRAME_DOTS     = LINE_DOTS * FRAME_LINES;
    // display held on across the startup line and the lines after it
    localparam int DEEP_TICKS     = 900;
    localparam int QUIET_TAIL     = 300;
    localparam int STALL_CYCLES   = 300;
    localparam int TIMEOUT_CYCLES = 12_000_000;

    logic              clk;
    logic              rst_n;

    logic              in_valid;
    logic              in_ready;
    logic              lcd_enable;
    logic [7:0]        lyc;
    logic [7:0]        wy;
    logic              transfer_done;

    logic              out_valid;
    logic              out_ready;
    logic [LINE_W-1:0] line;
    logic [DOT_W-1:0]  dot;
    logic [1:0]        stat_mode;
    logic              lyc_match;
    logic              vblank_irq;
    logic              oam_irq;
    logic              hblank_start;
    logic              render_start;
    logic              window_line_hit;
    logic              frame_commit;
    logic              screen_clear;

    int                error_count;
    int                ticks_outstanding;
    int                ticks_checked;
    int                vblank_count;
    int                commit_count;

    // stimulus control, written just after a rising edge and read at falling edges
    logic              quiet;
    logic              hold_request;
    int                cycle_count;
    int                ticks_sent;

    lcd_line_timing dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .lcd_enable      (lcd_enable),
        .lyc             (lyc),
        .wy              (wy),
        .transfer_done   (transfer_done),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .line            (line),
        .dot             (dot),
        .stat_mode       (stat_mode),
        .lyc_match       (lyc_match),
        .vblank_irq      (vblank_irq),
        .oam_irq         (oam_irq),
        .hblank_start    (hblank_start),
        .render_start    (render_start),
        .window_line_hit (window_line_hit),
        .frame_commit    (frame_commit),
        .screen_clear    (screen_clear)
    );

    lcd_timing_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .lcd_enable        (lcd_enable),
        .lyc               (lyc),
        .wy                (wy),
        .transfer_done     (transfer_done),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .line              (line),
        .dot               (dot),
        .stat_mode         (stat_mode),
        .lyc_match         (lyc_match),
        .vblank_irq        (vblank_irq),
        .oam_irq           (oam_irq),
        .hblank_start      (hblank_start),
        .render_start      (render_start),
        .window_line_hit   (window_line_hit),
        .frame_commit      (frame_commit),
        .screen_clear      (screen_clear),
        .error_count       (error_count),
        .ticks_outstanding (ticks_outstanding),
        .ticks_checked     (ticks_checked),
        .vblank_count      (vblank_count),
        .commit_count      (commit_count)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, ticks_outstanding);
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off when asked,
    // always ready once the quiet tail starts
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                // long hold while requests keep coming: the result register
                // fills and in_ready must drop
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // offer one dot tick request and wait until it is taken; an idle burst
    // may come before it while not in the quiet tail
    task automatic send_tick(input logic en, input logic [7:0] cmp,
                             input logic [7:0] wline, input logic done);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 15) == 0)
            gap = $urandom_range(1, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        lcd_enable    <= en;
        lyc           <= cmp;
        wy            <= wline;
        transfer_done <= done;
        do
            @(posedge clk);
        while (!in_ready);
        ticks_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results;
        @(negedge clk);
        in_valid <= 1'b0;
        while (ticks_outstanding != 0)
            @(negedge clk);
    endtask

    // display held on for long stretches; renderer done rate, lyc and wy
    // are chosen per line so that some lines match lyc, the window line
    // can match wy and some transfers run past the end of the line
    task automatic run_frames(input int total);
        int         k;
        int         seg;
        int         rate;
        logic [7:0] cmp;
        logic [7:0] wline;
        logic       done;
        rate  = 16;
        cmp   = 8'd0;
        wline = 8'($urandom_range(0, LAST_VISIBLE_LINE));
        for (k = 0; k < total; k++)
        begin
            if (total - k == QUIET_TAIL)
                quiet = 1'b1;
            if (k % LINE_DOTS == 0)
            begin
                seg = k / LINE_DOTS;
                case ($urandom_range(0, 15))
                    0:       rate = 0;      // no done: transfer runs to line end
                    1, 2, 3: rate = 4;
                    4, 5:    rate = 128;
                    default: rate = 32;
                endcase
                // segment k spans most of line k, so this usually matches
                if ($urandom_range(0, 7) == 0)
                    cmp = 8'(seg % FRAME_LINES);
                else
                    cmp = 8'($urandom);
                if ($urandom_range(0, 31) == 0)
                    wline = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(0, 150));
            end
            done = (rate != 0) && ($urandom_range(1, rate) == 1);
            send_tick(1'b1, cmp, wline, done);
        end
    endtask

    initial
    begin
        int k;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        lcd_enable    = 1'b0;
        lyc           = 8'd0;
        wy            = 8'd0;
        transfer_done = 1'b0;
        quiet         = 1'b0;
        hold_request  = 1'b0;
        cycle_count   = 0;
        ticks_sent    = 0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed: display off holds at line 0, lyc still compared
        send_tick(1'b0, 8'd0,   8'd0,   1'b0);
        send_tick(1'b0, 8'd255, 8'd255, 1'b1);
        // turn on with a stray done while still in hblank
        send_tick(1'b1, 8'd0,   8'd0,   1'b1);
        send_tick(1'b1, 8'd1,   8'd255, 1'b1);
        send_tick(1'b1, 8'd255, 8'd0,   1'b0);
        send_tick(1'b1, 8'd0,   8'd0,   1'b1);
        // turn off mid startup line, then stay off
        send_tick(1'b0, 8'd0,   8'd255, 1'b1);
        send_tick(1'b0, 8'd1,   8'd0,   1'b0);
        send_tick(1'b0, 8'd0,   8'd0,   1'b1);
        // turn on again and run a few dots with every input extreme
        send_tick(1'b1, 8'd255, 8'd0,   1'b0);
        send_tick(1'b1, 8'd0,   8'd255, 1'b1);
        send_tick(1'b1, 8'd128, 8'd127, 1'b0);
        send_tick(1'b1, 8'd127, 8'd128, 1'b1);
        send_tick(1'b1, 8'd0,   8'd0,   1'b0);
        // sender pause until every result is back
        drain_results();

        // noise: random fields, rare display toggles, stray dones
        for (k = 0; k < NOISE_TICKS; k++)
        begin
            if (k == 200)
                hold_request = 1'b1;
            send_tick($urandom_range(0, 199) != 0, 8'($urandom), 8'($urandom),
                      $urandom_range(0, 3) == 0);
        end

        // one off tick so the long run starts from a fresh turn on
        send_tick(1'b0, 8'($urandom), 8'($urandom), 1'b0);
        run_frames(DEEP_TICKS);
        // turn off at the end: screen clear and counters back to zero
        send_tick(1'b0, 8'd0, 8'd0, 1'b0);
        send_tick(1'b0, 8'd0, 8'd0, 1'b0);

        drain_results();
        // idle after the drain: any late result shows up as unexpected
        repeat (16) @(negedge clk);

        $display("%0d dot ticks sent, %0d results checked", ticks_sent, ticks_checked);
        $display("display toggles, startup lines, %0d vblank starts and %0d frame commits",
                 vblank_count, commit_count);
        if (error_count == 0 && ticks_outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
